// ----- design/fcp_pkg.sv -----
// Shared types and constants for the XOR-checked frame parser.
// Used by the parser, the output register and the top level; depends on nothing.
package fcp_pkg;

  // Parse states, in the order a frame walks through them.
  typedef enum logic [1:0] {
    ST_HEAD1 = 2'd0,
    ST_HEAD2 = 2'd1,
    ST_LEN   = 2'd2,
    ST_BODY  = 2'd3
  } fcp_state_t;

  localparam logic [7:0] HEAD_FIRST  = 8'h55;
  localparam logic [7:0] HEAD_SECOND = 8'hAA;
  localparam logic [7:0] LED_FUNC    = 8'h06;
  localparam logic [7:0] LED_MIN_LEN = 8'd3;

  // Body byte positions that are captured; anything later is only XORed.
  typedef enum logic [1:0] {
    POS_FUNC  = 2'd0,
    POS_DATA0 = 2'd1,
    POS_DATA1 = 2'd2,
    POS_REST  = 2'd3
  } body_pos_t;

  typedef struct packed {
    logic       checksum_ok;
    logic [7:0] func_code;
    logic [2:0] body_length;
    logic       led_command;
    logic [7:0] led_index;
    logic       led_on;
  } fcp_result_t;

endpackage

// ----- design/fcp_parser.sv -----
// Frame parsing state machine: header hunt, length check, body capture, XOR check.
// Depends on fcp_pkg; consumes one registered byte per step and builds the result.
module fcp_parser #(
  parameter int MAX_FRAME_BYTES = 11
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          byte_in,
  output logic                res_valid,
  output fcp_pkg::fcp_result_t res
);

  localparam int         LEN_W   = $clog2(MAX_FRAME_BYTES - 3);
  localparam logic [7:0] MAX_LEN = 8'(MAX_FRAME_BYTES - 4);

  fcp_pkg::fcp_state_t   state, state_next;
  fcp_pkg::body_pos_t    pos, pos_next;
  logic [7:0]            running_xor, running_xor_next;
  logic [LEN_W-1:0]      body_left, body_left_next;
  logic [LEN_W-1:0]      frame_len, frame_len_next;
  logic [7:0]            func, func_next;
  logic [7:0]            data0, data0_next;
  logic [7:0]            data1, data1_next;
  logic [7:0]            len8;
  logic                  ok;
  logic                  led;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fcp_pkg::ST_HEAD1;
      pos       <= fcp_pkg::POS_FUNC;
      body_left <= '0;
    end else if (step) begin
      state     <= state_next;
      pos       <= pos_next;
      body_left <= body_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      running_xor <= running_xor_next;
      frame_len   <= frame_len_next;
      func        <= func_next;
      data0       <= data0_next;
      data1       <= data1_next;
    end
  end

  assign len8 = 8'(frame_len);
  assign ok   = (byte_in == running_xor);
  assign led  = ok && (func == fcp_pkg::LED_FUNC) && (len8 >= fcp_pkg::LED_MIN_LEN);

  always_comb begin
    res.checksum_ok = ok;
    res.func_code   = func;
    res.body_length = len8[2:0];
    res.led_command = led;
    res.led_index   = led ? data0 : 8'd0;
    res.led_on      = led && (data1 != 8'd0);
  end

  always_comb begin
    state_next       = state;
    pos_next         = pos;
    running_xor_next = running_xor;
    body_left_next   = body_left;
    frame_len_next   = frame_len;
    func_next        = func;
    data0_next       = data0;
    data1_next       = data1;
    res_valid        = 1'b0;
    unique case (state)
      fcp_pkg::ST_HEAD1: begin
        if (byte_in == fcp_pkg::HEAD_FIRST) begin
          running_xor_next = byte_in;
          state_next       = fcp_pkg::ST_HEAD2;
        end
      end
      fcp_pkg::ST_HEAD2: begin
        priority if (byte_in == fcp_pkg::HEAD_SECOND) begin
          running_xor_next = running_xor ^ byte_in;
          state_next       = fcp_pkg::ST_LEN;
        end else if (byte_in == fcp_pkg::HEAD_FIRST) begin
          running_xor_next = byte_in;
        end else begin
          state_next = fcp_pkg::ST_HEAD1;
        end
      end
      fcp_pkg::ST_LEN: begin
        if ((byte_in == 8'd0) || (byte_in > MAX_LEN)) begin
          state_next = fcp_pkg::ST_HEAD1;
        end else begin
          frame_len_next   = byte_in[LEN_W-1:0];
          body_left_next   = byte_in[LEN_W-1:0];
          running_xor_next = running_xor ^ byte_in;
          pos_next         = fcp_pkg::POS_FUNC;
          func_next        = 8'd0;
          data0_next       = 8'd0;
          data1_next       = 8'd0;
          state_next       = fcp_pkg::ST_BODY;
        end
      end
      fcp_pkg::ST_BODY: begin
        if (body_left != '0) begin
          unique case (pos)
            fcp_pkg::POS_FUNC:  func_next  = byte_in;
            fcp_pkg::POS_DATA0: data0_next = byte_in;
            fcp_pkg::POS_DATA1: data1_next = byte_in;
            fcp_pkg::POS_REST:  ;
          endcase
          if (pos != fcp_pkg::POS_REST) begin
            pos_next = fcp_pkg::body_pos_t'(pos + 2'd1);
          end
          running_xor_next = running_xor ^ byte_in;
          body_left_next   = body_left - LEN_W'(1);
        end else begin
          // The byte after the body is the checksum; the frame ends here.
          res_valid        = 1'b1;
          running_xor_next = 8'd0;
          pos_next         = fcp_pkg::POS_FUNC;
          state_next       = fcp_pkg::ST_HEAD1;
        end
      end
      default: state_next = fcp_pkg::ST_HEAD1;
    endcase
  end

endmodule

// ----- design/fcp_out_reg.sv -----
// Result register between the parser and the output channel.
// Depends on fcp_pkg; loads a new result whenever it is empty or being drained.
module fcp_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 res_valid,
  input  fcp_pkg::fcp_result_t res,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fcp_pkg::fcp_result_t out_res
);

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// ----- design/xor_checked_frame_parser_top.sv -----
// Top level of the XOR-checked frame parser: input register, parser, result register.
// Depends on fcp_pkg, fcp_parser and fcp_out_reg.
//
//   channel   signals                      direction  content
//   input     in_valid/in_ready, rx_byte   in         one received byte
//   output    out_valid/out_ready, fields  out        one result per completed frame
//
// One byte a cycle is sustained while the output does not stall. A byte is parsed
// from the input register; any result is then offered by the result register.
// The input register and the result register both advance together whenever the
// result register is empty or being drained, so a stall on the output backs up
// into in_ready within the same cycle. Reset (rst, synchronous) returns the parser
// to the header hunt and empties both registers.
module xor_checked_frame_parser_top #(
  parameter int MAX_FRAME_BYTES = 11
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       checksum_ok,
  output logic [7:0] func_code,
  output logic [2:0] body_length,
  output logic       led_command,
  output logic [7:0] led_index,
  output logic       led_on
);

  logic                 advance;
  logic                 byte_valid;
  logic [7:0]           byte_q;
  logic                 res_valid;
  fcp_pkg::fcp_result_t res;
  fcp_pkg::fcp_result_t out_res;

  assign in_ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_q <= rx_byte;
    end
  end

  fcp_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (advance && byte_valid),
    .byte_in  (byte_q),
    .res_valid(res_valid),
    .res      (res)
  );

  fcp_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .res_valid(res_valid && byte_valid),
    .res      (res),
    .can_load (advance),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign checksum_ok = out_res.checksum_ok;
  assign func_code   = out_res.func_code;
  assign body_length = out_res.body_length;
  assign led_command = out_res.led_command;
  assign led_index   = out_res.led_index;
  assign led_on      = out_res.led_on;

endmodule

// ----- design/fcp_checker.sv -----
// Port-level checks for the XOR-checked frame parser, bound to the top level.
// Depends on fcp_pkg and the top level's ports.
module fcp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] rx_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic       checksum_ok,
  input logic [7:0] func_code,
  input logic [2:0] body_length,
  input logic       led_command,
  input logic [7:0] led_index,
  input logic       led_on
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(checksum_ok) && $stable(func_code)
      && $stable(body_length) && $stable(led_command) && $stable(led_index)
      && $stable(led_on))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // An LED command needs a good checksum and the LED function code.
  a_led_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && led_command |-> checksum_ok && func_code == fcp_pkg::LED_FUNC)
    else $error("LED command without good checksum or LED function");

  // Without an LED command the LED fields are cleared.
  a_led_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !led_command |-> led_index == 8'd0 && !led_on)
    else $error("LED fields set without LED command");

  // A byte offered on the input is held until its transfer.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(rx_byte))
    else $error("input byte changed while stalled");

endmodule

bind xor_checked_frame_parser_top fcp_checker u_fcp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .rx_byte    (rx_byte),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .checksum_ok(checksum_ok),
  .func_code  (func_code),
  .body_length(body_length),
  .led_command(led_command),
  .led_index  (led_index),
  .led_on     (led_on)
);
